@@ design/mtrr_large_page_memory_type_defines.svh @@
// Assertion macros shared by the checker of the MTRR large-page type resolver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MTRR_LARGE_PAGE_MEMORY_TYPE_DEFINES_SVH
`define MTRR_LARGE_PAGE_MEMORY_TYPE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLPMT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlpmt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MLPMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlpmt next-cycle check failed");

`endif

@@ design/mlpmt_pkg.sv @@
// Package for the MTRR large-page memory type resolver.
// Holds the beat types, the memory type codes, the state enum and the control structs.
`default_nettype none

package mlpmt_pkg;

    localparam int ADDR_W          = 52;
    localparam int BASE_W          = 40;
    localparam int PAGE_W          = 31;
    localparam int KIND_W          = 3;
    localparam int LARGE_SHIFT     = 21;
    localparam int SMALL_SHIFT     = 12;
    localparam int ENTRY_W         = 2 * ADDR_W + KIND_W;
    localparam int MAX_RANGES_DEF  = 16;

    localparam logic [KIND_W-1:0] TYPE_UC = 3'd0;
    localparam logic [KIND_W-1:0] TYPE_WB = 3'd6;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // One request beat.
    typedef struct packed {
        logic              cmd;
        logic [BASE_W-1:0] base_page;
        logic [BASE_W-1:0] mask_page;
        logic [KIND_W-1:0] range_kind;
        logic              range_on;
        logic [PAGE_W-1:0] large_page_number;
    } mlpmt_req_t;

    // One result beat.
    typedef struct packed {
        logic [KIND_W-1:0] memory_type;
        logic              range_kept;
        logic              table_full;
    } mlpmt_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_CHK,
        ST_LOAD_WR,
        ST_RES_CHK,
        ST_WALK,
        ST_DONE
    } mlpmt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic set_full;
        logic set_kept;
        logic set_uc;
        logic ram_write;
        logic walk_init;
        logic walk_issue;
    } mlpmt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_resolve;
        logic load_skip;
        logic load_full;
        logic table_empty;
        logic page_zero;
        logic issue_ok;
        logic cmp_pending;
        logic uc_hit;
    } mlpmt_status_t;

endpackage

`default_nettype wire

@@ design/mlpmt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module mlpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/mlpmt_ctrl.sv @@
// Controller state machine of the MTRR large-page memory type resolver.
// Depends on mlpmt_pkg for the state enum and the command and status structs.
`default_nettype none

module mlpmt_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire mlpmt_pkg::mlpmt_status_t status,
    output mlpmt_pkg::mlpmt_cmd_t        cmd,
    output logic                         busy,
    output logic                         done
);
    import mlpmt_pkg::*;

    mlpmt_state_t state_reg;
    mlpmt_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK:
            begin
                // The captured beat decides which path it takes.
                if (status.is_resolve)
                begin
                    state_next = ST_RES_CHK;
                end
                else if (status.load_skip)
                begin
                    state_next = ST_DONE;
                end
                else if (status.load_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOAD_WR;
                end
            end
            ST_LOAD_WR:
            begin
                cmd.ram_write = 1'b1;
                cmd.set_kept  = 1'b1;
                state_next    = ST_DONE;
            end
            ST_RES_CHK:
            begin
                if (status.table_empty)
                begin
                    state_next = ST_DONE;
                end
                else if (status.page_zero)
                begin
                    cmd.set_uc = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Reads are issued back to back; a UC hit ends the walk.
                cmd.walk_issue = status.issue_ok && !status.uc_hit;
                if (status.uc_hit || (!status.issue_ok && !status.cmp_pending))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/mlpmt_dpath.sv @@
// Datapath of the MTRR large-page memory type resolver: request and result
// registers, the range table in RAM, bound arithmetic and the overlap compare.
// Depends on mlpmt_pkg and mlpmt_ram.
`default_nettype none

module mlpmt_dpath #(
    parameter int MAX_RANGES = mlpmt_pkg::MAX_RANGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mlpmt_pkg::mlpmt_req_t request,
    input  wire mlpmt_pkg::mlpmt_cmd_t cmd,
    output mlpmt_pkg::mlpmt_status_t   status,
    output mlpmt_pkg::mlpmt_res_t      result
);
    import mlpmt_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    mlpmt_req_t        req_reg;
    mlpmt_res_t        res_reg;
    mlpmt_res_t        res_next;
    logic [BASE_W-1:0] fill_reg;
    logic [BASE_W-1:0] fill_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  rd_idx_next;
    logic              cmp_pend_reg;
    logic              cmp_pend_next;

    logic [ADDR_W-1:0]  span_lo;
    logic [ADDR_W:0]    span_sum;
    logic [ADDR_W-1:0]  span_hi;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ADDR_W-1:0]  rd_lo;
    logic [ADDR_W-1:0]  rd_hi;
    logic [KIND_W-1:0]  rd_kind;
    logic [ADDR_W-1:0]  page_start;
    logic [ADDR_W-1:0]  page_end;
    logic               hit;

    // Range bounds: the fill holds the ones below the lowest set mask bit,
    // so low plus the fill extended by 4K gives the last byte. A zero mask
    // fills all bits and lands on the saturated top address.
    assign fill_next = ~req_reg.mask_page & (req_reg.mask_page - BASE_W'(1));
    assign span_lo   = {req_reg.base_page, {SMALL_SHIFT{1'b0}}};
    assign span_sum  = {1'b0, span_lo} + {1'b0, fill_reg, {SMALL_SHIFT{1'b1}}};
    assign span_hi   = span_sum[ADDR_W] ? {ADDR_W{1'b1}} : span_sum[ADDR_W-1:0];
    assign wdata     = {span_lo, span_hi, req_reg.range_kind};

    mlpmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_write),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (cmd.walk_issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    // Overlap compare of the entry that the last read returned.
    assign rd_lo      = rdata[ENTRY_W-1 -: ADDR_W];
    assign rd_hi      = rdata[KIND_W +: ADDR_W];
    assign rd_kind    = rdata[KIND_W-1:0];
    assign page_start = {req_reg.large_page_number, {LARGE_SHIFT{1'b0}}};
    assign page_end   = {req_reg.large_page_number, {LARGE_SHIFT{1'b1}}};
    assign hit        = cmp_pend_reg && (page_start <= rd_hi) && (page_end >= rd_lo);

    // Next values of the control registers.
    always_comb
    begin
        count_next    = cmd.ram_write ? count_reg + CNT_W'(1) : count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_pend_next = cmd.walk_issue;
        if (cmd.walk_init)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.walk_issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    // Next value of the result beat.
    always_comb
    begin
        res_next = res_reg;
        if (cmd.capture)
        begin
            res_next.memory_type = (request.cmd == CMD_RESOLVE) ? TYPE_WB : TYPE_UC;
            res_next.range_kept  = 1'b0;
            res_next.table_full  = 1'b0;
        end
        if (cmd.set_full)
        begin
            res_next.table_full = 1'b1;
        end
        if (cmd.set_kept)
        begin
            res_next.range_kept = 1'b1;
        end
        if (cmd.set_uc)
        begin
            res_next.memory_type = TYPE_UC;
        end
        if (hit)
        begin
            res_next.memory_type = rd_kind;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            cmp_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        fill_reg <= fill_next;
        res_reg  <= res_next;
    end

    // Status toward the controller.
    always_comb
    begin
        status.is_resolve  = (req_reg.cmd == CMD_RESOLVE);
        status.load_skip   = !req_reg.range_on || (req_reg.range_kind == TYPE_WB);
        status.load_full   = (count_reg == CNT_W'(MAX_RANGES));
        status.table_empty = (count_reg == '0);
        status.page_zero   = (req_reg.large_page_number == '0);
        status.issue_ok    = (rd_idx_reg < count_reg);
        status.cmp_pending = cmp_pend_reg;
        status.uc_hit      = hit && (rd_kind == TYPE_UC);
    end

    assign result = res_reg;

endmodule

`default_nettype wire

@@ design/mtrr_large_page_memory_type.sv @@
// MTRR large-page memory type resolver, top level.
// Usage:
//   A request beat is taken when start is high and busy is low. Its cmd field
//   selects a load (store one variable range in the table) or a resolve (find
//   the memory type of one 2 MB page).
//   Each request gives exactly one result beat, shown on result for one cycle
//   while done is high. The receiver cannot stall; it must take the beat.
// Flow and throughput:
//   A stored load passes through the load check and the table write before
//   done; an ignored or dropped load goes from the load check straight to done.
//   A resolve goes from its check straight to done when the table is empty or
//   the page is zero, and otherwise walks the stored ranges, one table read per
//   cycle through the RAM's registered read port; a UC hit ends the walk
//   early. busy stays high through the done cycle, so one request is in work
//   at a time and the next one can be taken in the cycle after done.
// Reset:
//   rst_n clears the state machine and the stored range count, so the table
//   reads as empty. Table entries themselves are not cleared.
// Depends on mlpmt_pkg, mlpmt_ctrl, mlpmt_dpath and mlpmt_ram.
`default_nettype none

module mtrr_large_page_memory_type #(
    parameter int MAX_RANGES = mlpmt_pkg::MAX_RANGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire mlpmt_pkg::mlpmt_req_t request,
    output logic                       busy,
    output logic                       done,
    output mlpmt_pkg::mlpmt_res_t      result
);
    import mlpmt_pkg::*;

    mlpmt_cmd_t    cmd;
    mlpmt_status_t status;

    // Sequencing of loads and table walks.
    mlpmt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Range table, bounds and compare.
    mlpmt_dpath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ design/mlpmt_checker.sv @@
// Port-level checker for the MTRR large-page memory type resolver, bound to the top.
// Depends on mlpmt_pkg and the assertion macros header.
`default_nettype none

`include "mtrr_large_page_memory_type_defines.svh"

module mlpmt_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire mlpmt_pkg::mlpmt_res_t result
);
    import mlpmt_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    `MLPMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A result beat only appears while a request is in work.
    `MLPMT_ASSERT_SAME(a_done_busy, done, busy)
    // Each result beat lasts one cycle.
    `MLPMT_ASSERT_NEXT(a_done_single, done, !done)
    // A load cannot both keep and drop its range.
    `MLPMT_ASSERT_SAME(a_kept_full, done, !(result.range_kept && result.table_full))

endmodule

bind mtrr_large_page_memory_type mlpmt_checker u_mlpmt_checker (.*);

`default_nettype wire
